[src/s5hs_pkg.sv]
// Shared types and constants of the SOCKS5 handshake parser.
package s5hs_pkg;

  // Command queue depth between parser and reply generator
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Credential bytes that can ever match
  localparam int CRED_BYTES = 16;

  // Configuration register indexes
  localparam logic [2:0] REG_USER_LEN = 3'd0;
  localparam logic [2:0] REG_PASS_LEN = 3'd1;
  localparam logic [2:0] REG_USER_LO  = 3'd2;
  localparam logic [2:0] REG_USER_HI  = 3'd3;
  localparam logic [2:0] REG_PASS_LO  = 3'd4;
  localparam logic [2:0] REG_PASS_HI  = 3'd5;

  // Protocol bytes
  localparam logic [7:0] SOCKS_VER       = 8'h05;
  localparam logic [7:0] METHOD_USERPASS = 8'h02;
  localparam logic [7:0] METHOD_NONE     = 8'hFF;
  localparam logic [7:0] AUTH_VER        = 8'h01;
  localparam logic [7:0] AUTH_OK         = 8'h00;
  localparam logic [7:0] AUTH_FAIL       = 8'h01;
  localparam logic [7:0] REP_CMD_UNSUP   = 8'h07;
  localparam logic [7:0] REP_ATYP_UNSUP  = 8'h08;
  localparam logic [7:0] CMD_CONNECT     = 8'h01;
  localparam logic [7:0] ATYP_IPV4       = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
  localparam logic [7:0] ATYP_IPV6       = 8'h04;

  // Result kinds
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_ADDR    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_PAYLOAD = 2'd3;

  // Address kinds
  localparam logic [1:0] AK_IPV4   = 2'd0;
  localparam logic [1:0] AK_DOMAIN = 2'd1;
  localparam logic [1:0] AK_IPV6   = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_session;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] dest_port;
    logic [1:0]  addr_kind;
    logic        close_after;
    logic        last;
  } out_t;

  // Work handed from parser to reply generator
  typedef enum logic [2:0] {
    OP_PAIR,
    OP_REPLY10,
    OP_ADDR,
    OP_DONE,
    OP_PAYLOAD
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] port;
    logic [1:0]  addr_kind;
    logic        close_flag;
  } cmd_t;

endpackage

[src/s5hs_front.sv]
// Byte parser: handshake state machine, credential check and config registers.
module s5hs_front import s5hs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_t         in_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  typedef enum logic [3:0] {
    PH_GVER, PH_GNM, PH_GMETH, PH_AVER, PH_AULEN, PH_AUSER, PH_APLEN,
    PH_APASS, PH_RHDR, PH_RDLEN, PH_RADDR, PH_RPORT, PH_PAYLOAD, PH_DEAD
  } phase_t;

  localparam int CRED_LIMIT = (CRED_BYTES < 16) ? CRED_BYTES : 16;

  // Config registers
  logic [4:0]  user_len, pass_len;
  logic [63:0] user_lo, user_hi, pass_lo, pass_hi;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  field_length, field_length_next;
  logic        method_seen, method_seen_next;
  logic        cred_match, cred_match_next;
  logic [7:0]  client_user_len, client_user_len_next;
  logic [7:0]  addr_type, addr_type_next;
  logic [7:0]  command_code, command_code_next;
  logic [15:0] port_hold, port_hold_next;

  // State as seen by this byte (returned to its start values first on a new session)
  phase_t      c_phase;
  logic [7:0]  c_byte_index, c_field_length, c_client_user_len, c_addr_type;
  logic [7:0]  c_command_code;
  logic        c_method_seen, c_cred_match;
  logic [15:0] c_port_hold;

  logic [7:0]  b, bi_inc;
  logic        ms, m;
  logic [15:0] port_full;
  logic [1:0]  cur_ak;

  // Does byte b match credential byte idx
  function automatic logic cred_ok(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [7:0] idx, input logic [7:0] bv);
    logic [127:0] words;
    logic [7:0]   cb;
    words = {hi, lo};
    cb = words[{idx[3:0], 3'b000} +: 8];
    return (idx < 8'(CRED_LIMIT)) && (cb == bv);
  endfunction

  function automatic logic [1:0] ak_of(input logic [7:0] atyp);
    if (atyp == ATYP_DOMAIN) return AK_DOMAIN;
    if (atyp == ATYP_IPV6) return AK_IPV6;
    return AK_IPV4;
  endfunction

  assign b = in_item.in_byte;

  // Session restart view
  always_comb begin
    c_phase           = in_item.new_session ? PH_GVER : phase;
    c_byte_index      = in_item.new_session ? 8'd0 : byte_index;
    c_field_length    = in_item.new_session ? 8'd0 : field_length;
    c_method_seen     = in_item.new_session ? 1'b0 : method_seen;
    c_cred_match      = in_item.new_session ? 1'b1 : cred_match;
    c_client_user_len = in_item.new_session ? 8'd0 : client_user_len;
    c_addr_type       = in_item.new_session ? 8'd0 : addr_type;
    c_command_code    = in_item.new_session ? 8'd0 : command_code;
    c_port_hold       = in_item.new_session ? 16'd0 : port_hold;
  end

  assign bi_inc    = c_byte_index + 8'd1;
  assign cur_ak    = ak_of(c_addr_type);
  assign port_full = c_port_hold | {8'h00, b};

  // Next state and command for the accepted byte
  always_comb begin
    phase_next           = c_phase;
    byte_index_next      = c_byte_index;
    field_length_next    = c_field_length;
    method_seen_next     = c_method_seen;
    cred_match_next      = c_cred_match;
    client_user_len_next = c_client_user_len;
    addr_type_next       = c_addr_type;
    command_code_next    = c_command_code;
    port_hold_next       = c_port_hold;
    cmd_valid            = 1'b0;
    cmd                  = '0;
    ms                   = c_method_seen | (b == METHOD_USERPASS);
    m                    = c_cred_match;
    case (c_phase)
      PH_GVER: begin
        phase_next = (b == SOCKS_VER) ? PH_GNM : PH_DEAD;
      end
      PH_GNM: begin
        if (b == 8'd0) begin
          phase_next = PH_DEAD;
        end else begin
          field_length_next = b;
          byte_index_next   = 8'd0;
          method_seen_next  = 1'b0;
          phase_next        = PH_GMETH;
        end
      end
      PH_GMETH: begin
        method_seen_next = ms;
        byte_index_next  = bi_inc;
        if (bi_inc >= c_field_length) begin
          cmd_valid      = 1'b1;
          cmd.op         = OP_PAIR;
          cmd.first      = SOCKS_VER;
          cmd.second     = ms ? METHOD_USERPASS : METHOD_NONE;
          cmd.close_flag = !ms;
          phase_next     = ms ? PH_AVER : PH_DEAD;
        end
      end
      PH_AVER: begin
        phase_next = (b == AUTH_VER) ? PH_AULEN : PH_DEAD;
      end
      PH_AULEN: begin
        client_user_len_next = b;
        cred_match_next      = (b == {3'b000, user_len});
        byte_index_next      = 8'd0;
        phase_next           = (b == 8'd0) ? PH_APLEN : PH_AUSER;
      end
      PH_AUSER: begin
        cred_match_next = c_cred_match & cred_ok(user_lo, user_hi, c_byte_index, b);
        byte_index_next = bi_inc;
        if (bi_inc >= c_client_user_len) begin
          phase_next = PH_APLEN;
        end
      end
      PH_APLEN, PH_APASS: begin
        if (c_phase == PH_APLEN) begin
          m                 = c_cred_match & (b == {3'b000, pass_len});
          field_length_next = b;
          byte_index_next   = 8'd0;
        end else begin
          m               = c_cred_match & cred_ok(pass_lo, pass_hi, c_byte_index, b);
          byte_index_next = bi_inc;
        end
        cred_match_next = m;
        if ((c_phase == PH_APLEN) ? (b == 8'd0) : (bi_inc >= c_field_length)) begin
          // Sub-negotiation complete: answer status
          cmd_valid      = 1'b1;
          cmd.op         = OP_PAIR;
          cmd.first      = AUTH_VER;
          cmd.second     = m ? AUTH_OK : AUTH_FAIL;
          cmd.close_flag = !m;
          if (m) begin
            phase_next      = PH_RHDR;
            byte_index_next = 8'd0;
          end else begin
            phase_next = PH_DEAD;
          end
        end else if (c_phase == PH_APLEN) begin
          phase_next = PH_APASS;
        end
      end
      PH_RHDR: begin
        if (c_byte_index == 8'd0) begin
          if (b == SOCKS_VER) byte_index_next = 8'd1;
          else phase_next = PH_DEAD;
        end else if (c_byte_index == 8'd1) begin
          command_code_next = b;
          byte_index_next   = 8'd2;
        end else if (c_byte_index == 8'd2) begin
          if (b == 8'd0) byte_index_next = 8'd3;
          else phase_next = PH_DEAD;
        end else begin
          addr_type_next  = b;
          byte_index_next = 8'd0;
          if (b == ATYP_IPV4) begin
            field_length_next = 8'd4;
            phase_next        = PH_RADDR;
          end else if (b == ATYP_DOMAIN) begin
            phase_next = PH_RDLEN;
          end else if (b == ATYP_IPV6) begin
            field_length_next = 8'd16;
            phase_next        = PH_RADDR;
          end else begin
            cmd_valid      = 1'b1;
            cmd.op         = OP_REPLY10;
            cmd.second     = REP_ATYP_UNSUP;
            cmd.close_flag = 1'b1;
            phase_next     = PH_DEAD;
          end
        end
      end
      PH_RDLEN: begin
        field_length_next = b;
        byte_index_next   = 8'd0;
        phase_next        = (b == 8'd0) ? PH_RPORT : PH_RADDR;
      end
      PH_RADDR: begin
        cmd_valid       = 1'b1;
        cmd.op          = OP_ADDR;
        cmd.first       = b;
        cmd.addr_kind   = cur_ak;
        byte_index_next = bi_inc;
        if (bi_inc >= c_field_length) begin
          byte_index_next = 8'd0;
          phase_next      = PH_RPORT;
        end
      end
      PH_RPORT: begin
        if (c_byte_index == 8'd0) begin
          port_hold_next  = {b, 8'h00};
          byte_index_next = 8'd1;
        end else begin
          port_hold_next  = port_full;
          byte_index_next = 8'd0;
          cmd_valid       = 1'b1;
          if (c_command_code == CMD_CONNECT) begin
            cmd.op        = OP_DONE;
            cmd.port      = port_full;
            cmd.addr_kind = cur_ak;
            phase_next    = PH_PAYLOAD;
          end else begin
            cmd.op         = OP_REPLY10;
            cmd.second     = REP_CMD_UNSUP;
            cmd.close_flag = 1'b1;
            phase_next     = PH_DEAD;
          end
        end
      end
      PH_PAYLOAD: begin
        cmd_valid = 1'b1;
        cmd.op    = OP_PAYLOAD;
        cmd.first = b;
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
  end

  // State and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_GVER;
      byte_index      <= 8'd0;
      field_length    <= 8'd0;
      method_seen     <= 1'b0;
      cred_match      <= 1'b1;
      client_user_len <= 8'd0;
      addr_type       <= 8'd0;
      command_code    <= 8'd0;
      port_hold       <= 16'd0;
      user_len        <= 5'd0;
      pass_len        <= 5'd0;
      user_lo         <= 64'd0;
      user_hi         <= 64'd0;
      pass_lo         <= 64'd0;
      pass_hi         <= 64'd0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        byte_index      <= byte_index_next;
        field_length    <= field_length_next;
        method_seen     <= method_seen_next;
        cred_match      <= cred_match_next;
        client_user_len <= client_user_len_next;
        addr_type       <= addr_type_next;
        command_code    <= command_code_next;
        port_hold       <= port_hold_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_USER_LEN: user_len <= cfg_data[4:0];
          REG_PASS_LEN: pass_len <= cfg_data[4:0];
          REG_USER_LO:  user_lo  <= cfg_data;
          REG_USER_HI:  user_hi  <= cfg_data;
          REG_PASS_LO:  pass_lo  <= cfg_data;
          REG_PASS_HI:  pass_hi  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[src/s5hs_queue.sv]
// Command queue between the parser and the reply generator.
module s5hs_queue import s5hs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  output logic head_valid,
  output cmd_t head,
  input  logic pop
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  cmd_t               slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full       = (count == COUNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) count <= count + COUNT_W'(1);
      else if (pop && !push) count <= count - COUNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("queue count over depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("pop from empty queue");
`endif

endmodule

[src/s5hs_back.sv]
// Reply generator: expands queued commands into result transactions.
module s5hs_back import s5hs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  cmd_t head,
  output logic head_pop,
  output logic empty,
  output out_t out_item,
  input  logic pop
);

  logic [3:0] cnt;
  logic [3:0] n_items;
  logic       is_last, advance, out_valid;
  out_t       item;

  // Fixed ten-byte reply with a reply code in byte one
  function automatic logic [7:0] reply10_byte(input logic [3:0] idx, input logic [7:0] rep);
    if (idx == 4'd0) return SOCKS_VER;
    if (idx == 4'd1) return rep;
    if (idx == 4'd3) return ATYP_IPV4;
    return 8'h00;
  endfunction

  always_comb begin
    case (head.op)
      OP_PAIR:    n_items = 4'd2;
      OP_REPLY10: n_items = 4'd10;
      default:    n_items = 4'd1;
    endcase
  end

  assign is_last  = (cnt == n_items - 4'd1);
  assign advance  = head_valid && (!out_valid || pop);
  assign head_pop = advance && is_last;
  assign empty    = !out_valid;

  // Build the current result
  always_comb begin
    item             = '0;
    item.dest_port   = head.port;
    item.addr_kind   = head.addr_kind;
    item.close_after = head.close_flag;
    item.last        = is_last;
    case (head.op)
      OP_PAIR: begin
        item.kind     = KIND_REPLY;
        item.out_byte = (cnt == 4'd0) ? head.first : head.second;
      end
      OP_REPLY10: begin
        item.kind     = KIND_REPLY;
        item.out_byte = reply10_byte(cnt, head.second);
      end
      OP_ADDR: begin
        item.kind     = KIND_ADDR;
        item.out_byte = head.first;
      end
      OP_DONE: begin
        item.kind = KIND_DONE;
      end
      default: begin
        item.kind     = KIND_PAYLOAD;
        item.out_byte = head.first;
      end
    endcase
  end

  // Output register and item counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 4'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      cnt       <= is_last ? 4'd0 : cnt + 4'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= item;
  end

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (cnt < n_items))
    else $error("item counter past end of command");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind != KIND_REPLY) |-> out_item.last)
    else $error("single-item result without last");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(out_item)))
    else $error("waiting result changed before pop");
`endif

endmodule

[src/socks5_handshake_parser.sv]
// A byte's commands are registered in the command queue and then in the reply generator's
// output register before its first result shows on the outputs, where it can then be popped.
// The parser takes one byte per cycle while the queue is not full; the reply generator gives one
// result per cycle while pop keeps up, so a byte with n results (up to ten for a failure reply)
// holds it until all n are out, while the command queue (QUEUE_DEPTH entries) keeps taking bytes.
// Reset (synchronous, rst high): greeting phase, config registers zero, queue and output empty.
module socks5_handshake_parser import s5hs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         in_item,
  output logic        empty,
  input  logic        pop,
  output out_t        out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic accept;
  logic cmd_valid, head_valid, head_pop;
  cmd_t cmd, head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Parser front
  s5hs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Command queue
  s5hs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && cmd_valid),
    .push_data  (cmd),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (head_pop)
  );

  // Reply generator back
  s5hs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .out_item   (out_item),
    .pop        (pop)
  );

endmodule
